// ===== rtl/itaf_pkg.sv =====
package itaf_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W  = 7;

  // Default conversion width and the digit count that follows from it
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned DIGITS_DEF      = (VALUE_WIDTH_DEF + 2) / 3;

  // Cap on characters per number
  localparam int unsigned MAX_CHARS = 11;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 7'h46;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_OCT  = 2'd2,
    OP_HEX  = 2'd3
  } op_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    op_e                operation;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_item_t;

  // Control from the sequencer to the digit register
  typedef struct packed {
    logic clear;   // zero all digits
    logic step;    // correct and shift one binary bit in
    logic drop;    // discard the top digit, move the rest up
    logic bin_bit; // bit shifted in on a step
    op_e  kind;    // conversion kind of the item at work
  } dig_ctrl_t;

  // ASCII code of one digit, upper-case for ten and above
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_UPPER_A + {3'b000, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// ===== rtl/itaf_digit_reg.sv =====
module itaf_digit_reg import itaf_pkg::*; #(
  parameter int unsigned NDIG = DIGITS_DEF
) (
  input  logic       clk_i,
  input  dig_ctrl_t  ctrl_i,
  output logic [3:0] top_digit_o
);

  logic [NDIG-1:0][3:0] dig_q;
  logic [NDIG-1:0][3:0] dig_d;
  logic [NDIG-1:0][3:0] corr;
  logic [NDIG:0]        carry;
  logic                 is_dec;
  logic                 is_oct;

  assign is_dec = (ctrl_i.kind == OP_SDEC) || (ctrl_i.kind == OP_UDEC);
  assign is_oct = (ctrl_i.kind == OP_OCT);

  // Add three to decimal digits of five and above, then shift one bit up the chain
  always_comb begin
    carry[0] = ctrl_i.bin_bit;
    for (int i = 0; i < NDIG; i++) begin
      corr[i] = (is_dec && (dig_q[i] >= 4'd5)) ? dig_q[i] + 4'd3 : dig_q[i];
      if (is_oct) begin
        dig_d[i]   = {1'b0, corr[i][1:0], carry[i]};
        carry[i+1] = corr[i][2];
      end else begin
        dig_d[i]   = {corr[i][2:0], carry[i]};
        carry[i+1] = corr[i][3];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      dig_q <= '0;
    end else if (ctrl_i.step) begin
      dig_q <= dig_d;
    end else if (ctrl_i.drop) begin
      dig_q <= {dig_q[NDIG-2:0], 4'd0};
    end
  end

  assign top_digit_o = dig_q[NDIG-1];

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_item_i  (value, operation)
// out       output     out_valid_o / out_ready_i out_item_o (character, last)
//
// Steps: take the item, shift the value bit by bit through the digit register, drop the
//   leading zero digits, then emit the characters; the bit-serial shift takes the longest.
// Reset: rst_ni clears the sequencer and the output valid; digits need no reset.
// Stalls: a held output stalls character emission only; the last character may wait in
//   the output register while the next item is taken and converted.
module integer_to_ascii_formatter import itaf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // Enough digits for octal, which needs the most of the three radices
  localparam int unsigned NDIG    = (VALUE_WIDTH + 2) / 3;
  localparam int unsigned BIT_CW  = $clog2(VALUE_WIDTH);
  localparam int unsigned REM_CW  = $clog2(NDIG + 1);
  localparam int unsigned EMIT_CW = $clog2(MAX_CHARS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_e;

  state_e                   state_q;
  logic                     neg_q;
  logic [BIT_CW-1:0]        bit_cnt_q;
  logic [REM_CW-1:0]        rem_q;
  logic [EMIT_CW-1:0]       emit_cnt_q;
  logic                     out_valid_q;
  out_item_t                out_q;

  logic [VALUE_WIDTH-1:0]   bin_q;
  op_e                      kind_q;

  logic [VALUE_WIDTH+VALUE_W-1:0] value_ext;
  logic [VALUE_WIDTH-1:0]   value_in;
  logic                     load_neg;
  logic [VALUE_WIDTH-1:0]   load_mag;
  logic                     in_accept;
  logic                     out_load;
  logic [3:0]               top_digit;
  logic                     skip_zero;
  logic                     last_char;
  dig_ctrl_t                dig_ctrl;

  // Keep only the low VALUE_WIDTH bits, zero-extend where the width exceeds the field
  assign value_ext = {{VALUE_WIDTH{1'b0}}, in_item_i.value};
  assign value_in  = value_ext[VALUE_WIDTH-1:0];

  // Negative signed decimal: take the two's complement magnitude; the most negative
  // value maps onto itself, which is its unsigned magnitude
  assign load_neg  = (in_item_i.operation == OP_SDEC) && value_in[VALUE_WIDTH-1];
  assign load_mag  = load_neg ? (~value_in + VALUE_WIDTH'(1)) : value_in;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // Load a new character when the output register is empty or being taken
  assign out_load   = !out_valid_q || out_ready_i;

  // Drop a leading zero while more than one digit is left, so zero still gives '0'
  assign skip_zero  = (top_digit == 4'd0) && (rem_q != REM_CW'(1));
  assign last_char  = (rem_q == REM_CW'(1)) || (emit_cnt_q == EMIT_CW'(MAX_CHARS - 1));

  always_comb begin
    dig_ctrl.clear   = in_accept;
    dig_ctrl.step    = (state_q == S_CONV);
    dig_ctrl.drop    = ((state_q == S_SKIP) && skip_zero) ||
                       ((state_q == S_EMIT) && out_load && !neg_q);
    dig_ctrl.bin_bit = bin_q[VALUE_WIDTH-1];
    dig_ctrl.kind    = kind_q;
  end

  itaf_digit_reg #(
    .NDIG (NDIG)
  ) u_digit_reg (
    .clk_i       (clk_i),
    .ctrl_i      (dig_ctrl),
    .top_digit_o (top_digit)
  );

  // Binary value, shifted out MSB first into the digit register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      bin_q  <= load_mag;
      kind_q <= in_item_i.operation;
    end else if (state_q == S_CONV) begin
      bin_q  <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      bit_cnt_q   <= '0;
      rem_q       <= '0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Drop the output item once taken; during emission the case below handles it
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            neg_q     <= load_neg;
            bit_cnt_q <= BIT_CW'(VALUE_WIDTH - 1);
            state_q   <= S_CONV;
          end
        end
        S_CONV: begin
          // Advance one bit a cycle until the whole value has gone in
          bit_cnt_q <= bit_cnt_q - BIT_CW'(1);
          if (bit_cnt_q == '0) begin
            rem_q   <= REM_CW'(NDIG);
            state_q <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (skip_zero) begin
            rem_q      <= rem_q - REM_CW'(1);
          end else begin
            emit_cnt_q <= '0;
            state_q    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            emit_cnt_q  <= emit_cnt_q + EMIT_CW'(1);
            if (neg_q) begin
              // Sign goes first and is never the final character
              out_q.character <= CHAR_MINUS;
              out_q.last      <= 1'b0;
              neg_q           <= 1'b0;
            end else begin
              out_q.character <= digit_char(top_digit);
              out_q.last      <= last_char;
              rem_q           <= rem_q - REM_CW'(1);
              if (last_char) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/itaf_checker.sv =====
module itaf_checker import itaf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // Hold a stalled output item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  // Conversion occupies the block after an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again straight after an item");

  // A minus sign is always followed by digits
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.character == CHAR_MINUS) |-> !out_item_o.last)
    else $error("minus sign flagged as last character");

  // Only digits, upper-case hex letters and the minus sign appear
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_item_o.character >= CHAR_ZERO) && (out_item_o.character <= CHAR_NINE)) ||
      ((out_item_o.character >= CHAR_UPPER_A) && (out_item_o.character <= CHAR_UPPER_F)) ||
      (out_item_o.character == CHAR_MINUS))
    else $error("character outside the digit set");

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
